// File: hw/rtl/ahbc_pkg.sv
`default_nettype none

package ahbc_pkg;

	// segment counts and pattern geometry
	localparam int NUM_HIGH = 5;
	localparam int NUM_LOW = 6;
	localparam int WIN_BASE = 3;

	// configuration register indexes
	localparam logic [2:0] REG_THRESH_LOW = 3'd0;
	localparam logic [2:0] REG_THRESH_MID = 3'd1;
	localparam logic [2:0] REG_THRESH_HIGH = 3'd2;
	localparam logic [2:0] REG_DUTY_QUARTER = 3'd3;
	localparam logic [2:0] REG_DUTY_HALF = 3'd4;
	localparam logic [2:0] REG_DUTY_FULL = 3'd5;

	// configuration reset values
	localparam logic [14:0] RST_THRESH_LOW = 15'd4000;
	localparam logic [14:0] RST_THRESH_MID = 15'd8000;
	localparam logic [14:0] RST_THRESH_HIGH = 15'd12000;
	localparam logic [7:0] RST_DUTY_QUARTER = 8'd70;
	localparam logic [7:0] RST_DUTY_HALF = 8'd150;
	localparam logic [7:0] RST_DUTY_FULL = 8'd255;

	// camera link event codes
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_BYTE = 2'd1;
	localparam logic [1:0] EV_TIMEOUT = 2'd2;

	// beam modes
	localparam logic [1:0] MODE_DRL = 2'd1;
	localparam logic [1:0] MODE_LOW = 2'd2;
	localparam logic [1:0] MODE_HIGH = 2'd3;

	// camera word bits and fallback value
	localparam logic [7:0] DEFAULT_WORD = 8'h20;
	localparam int CAM_DARK_BIT = 5;
	localparam int CAM_SPEED_BIT = 6;

	typedef struct packed {
		logic        auto_on;
		logic        manual_high;
		logic        manual_drl;
		logic [1:0]  video_event;
		logic [7:0]  video_byte;
		logic signed [15:0] lateral_accel;
		logic        imu_fault;
	} item_t;

	typedef struct packed {
		logic [7:0] high_duty_0;
		logic [7:0] high_duty_1;
		logic [7:0] high_duty_2;
		logic [7:0] high_duty_3;
		logic [7:0] high_duty_4;
		logic [7:0] low_duty_0;
		logic [7:0] low_duty_1;
		logic [7:0] low_duty_2;
		logic [7:0] low_duty_3;
		logic [7:0] low_duty_4;
		logic [7:0] low_duty_5;
		logic [5:0] status_flags;
	} result_t;

	typedef struct packed {
		logic [14:0] thresh_low;
		logic [14:0] thresh_mid;
		logic [14:0] thresh_high;
		logic [7:0]  duty_quarter;
		logic [7:0]  duty_half;
		logic [7:0]  duty_full;
	} cfg_t;

	typedef struct packed {
		logic [7:0] word;
		logic       error;
	} cam_t;

	// 12-entry low beam pattern
	function automatic logic [7:0] low_pattern(input logic [1:0] mode, input logic [3:0] idx,
			input cfg_t cfg);
		logic [7:0] v;
		v = 8'd0;
		case (mode)
			MODE_DRL: v = cfg.duty_quarter;
			MODE_LOW: begin
				if (idx < 4'd3) v = cfg.duty_quarter;
				else if (idx < 4'd7 || idx >= 4'd9) v = cfg.duty_half;
				else v = cfg.duty_full;
			end
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	// 11-entry high beam pattern
	function automatic logic [7:0] high_pattern(input logic [1:0] mode, input logic [3:0] idx,
			input cfg_t cfg);
		logic [7:0] v;
		v = 8'd0;
		if (mode == MODE_HIGH) begin
			if (idx == 4'd0 || idx == 4'd10) v = cfg.duty_quarter;
			else if (idx < 4'd4 || idx == 4'd9) v = cfg.duty_half;
			else v = cfg.duty_full;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ahbc_cfg.sv
`default_nettype none

module ahbc_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [14:0] wr_data,
	output ahbc_pkg::cfg_t   cfg
);

	ahbc_pkg::cfg_t cfg_q;

	// register file, writes past the last index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thresh_low <= ahbc_pkg::RST_THRESH_LOW;
			cfg_q.thresh_mid <= ahbc_pkg::RST_THRESH_MID;
			cfg_q.thresh_high <= ahbc_pkg::RST_THRESH_HIGH;
			cfg_q.duty_quarter <= ahbc_pkg::RST_DUTY_QUARTER;
			cfg_q.duty_half <= ahbc_pkg::RST_DUTY_HALF;
			cfg_q.duty_full <= ahbc_pkg::RST_DUTY_FULL;
		end else if (wr_en) begin
			case (wr_index)
				ahbc_pkg::REG_THRESH_LOW: cfg_q.thresh_low <= wr_data;
				ahbc_pkg::REG_THRESH_MID: cfg_q.thresh_mid <= wr_data;
				ahbc_pkg::REG_THRESH_HIGH: cfg_q.thresh_high <= wr_data;
				ahbc_pkg::REG_DUTY_QUARTER: cfg_q.duty_quarter <= wr_data[7:0];
				ahbc_pkg::REG_DUTY_HALF: cfg_q.duty_half <= wr_data[7:0];
				ahbc_pkg::REG_DUTY_FULL: cfg_q.duty_full <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/ahbc_beam.sv
`default_nettype none

module ahbc_beam (
	input  wire ahbc_pkg::item_t item,
	input  wire ahbc_pkg::cfg_t  cfg,
	input  wire ahbc_pkg::cam_t  cam,
	output ahbc_pkg::cam_t    cam_nxt,
	output ahbc_pkg::result_t result
);

	logic [1:0] mode;
	logic signed [16:0] accel;
	logic signed [16:0] lo;
	logic signed [16:0] mi;
	logic signed [16:0] hi;
	logic signed [2:0] shift;
	logic [3:0] shift_ext;
	logic [3:0] idx;
	logic [7:0] hv;
	logic masked;
	logic [7:0] hd [ahbc_pkg::NUM_HIGH];
	logic [7:0] ld [ahbc_pkg::NUM_LOW];
	logic [5:0] status;

	// camera state update, ahead of mode choice
	always_comb begin
		cam_nxt = cam;
		if (!item.auto_on) begin
			cam_nxt.word = ahbc_pkg::DEFAULT_WORD;
			cam_nxt.error = 1'b1;
		end else if (item.video_event == ahbc_pkg::EV_BYTE) begin
			cam_nxt.word = item.video_byte;
			cam_nxt.error = 1'b0;
		end else if (item.video_event == ahbc_pkg::EV_TIMEOUT) begin
			cam_nxt.word = ahbc_pkg::DEFAULT_WORD;
			cam_nxt.error = 1'b1;
		end
	end

	// mode from camera in auto, else from the switches
	always_comb begin
		if (item.auto_on) begin
			if (cam_nxt.word[ahbc_pkg::CAM_DARK_BIT])
				mode = cam_nxt.word[ahbc_pkg::CAM_SPEED_BIT] ? ahbc_pkg::MODE_HIGH
					: ahbc_pkg::MODE_LOW;
			else
				mode = ahbc_pkg::MODE_DRL;
		end else begin
			if (item.manual_high) mode = ahbc_pkg::MODE_HIGH;
			else mode = item.manual_drl ? ahbc_pkg::MODE_DRL : ahbc_pkg::MODE_LOW;
		end
	end

	// steering shift, nested compares against the thresholds
	always_comb begin
		accel = {item.lateral_accel[15], item.lateral_accel};
		lo = {2'b00, cfg.thresh_low};
		mi = {2'b00, cfg.thresh_mid};
		hi = {2'b00, cfg.thresh_high};
		if (item.imu_fault) shift = 3'sd0;
		else if (accel > lo) begin
			if (accel > mi) shift = (accel > hi) ? -3'sd3 : -3'sd2;
			else shift = -3'sd1;
		end else if (accel < -lo) begin
			if (accel < -mi) shift = (accel < -hi) ? 3'sd3 : 3'sd2;
			else shift = 3'sd1;
		end else shift = 3'sd0;
		shift_ext = {shift[2], shift};
	end

	// pattern windows and glare masking
	always_comb begin
		idx = 4'd0;
		hv = 8'd0;
		masked = 1'b0;
		for (int i = 0; i < ahbc_pkg::NUM_LOW; i++) begin
			idx = 4'(ahbc_pkg::WIN_BASE + i) + shift_ext;
			ld[i] = ahbc_pkg::low_pattern(mode, idx, cfg);
		end
		for (int i = 0; i < ahbc_pkg::NUM_HIGH; i++) begin
			idx = 4'(ahbc_pkg::WIN_BASE + i) + shift_ext;
			hv = ahbc_pkg::high_pattern(mode, idx, cfg);
			if (item.auto_on && mode == ahbc_pkg::MODE_HIGH) begin
				masked = cam_nxt.word[3'(ahbc_pkg::NUM_HIGH - 1 - i)];
				hd[i] = masked ? 8'd0 : hv;
				ld[i + 1] = masked ? hv : 8'd0;
			end else begin
				hd[i] = hv;
			end
		end
	end

	// status flags
	always_comb begin
		status = 6'd0;
		status[0] = !item.auto_on;
		status[1] = (mode == ahbc_pkg::MODE_DRL);
		status[2] = (mode == ahbc_pkg::MODE_LOW);
		status[3] = (mode == ahbc_pkg::MODE_HIGH);
		status[4] = item.imu_fault;
		status[5] = cam_nxt.error;
	end

	always_comb begin
		result.high_duty_0 = hd[0];
		result.high_duty_1 = hd[1];
		result.high_duty_2 = hd[2];
		result.high_duty_3 = hd[3];
		result.high_duty_4 = hd[4];
		result.low_duty_0 = ld[0];
		result.low_duty_1 = ld[1];
		result.low_duty_2 = ld[2];
		result.low_duty_3 = ld[3];
		result.low_duty_4 = ld[4];
		result.low_duty_5 = ld[5];
		result.status_flags = status;
	end

endmodule

`default_nettype wire

// File: hw/rtl/adaptive_headlight_beam_control.sv
// path: an accepted beat is registered in the input stage, then in the result register;
//   it waits in the input stage while a waiting result holds the result register
// throughput: one beat per cycle unless the result register holds an undrained result;
//   a single pass through the beam logic between the input stage and result registers
// reset: arst_n clears valids and camera state and loads the default thresholds
//   and duties; the block is ready for beats as soon as reset is released
`default_nettype none

module adaptive_headlight_beam_control (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_ready,
	input  wire ahbc_pkg::item_t item,
	output logic              result_valid,
	input  wire logic         result_ready,
	output ahbc_pkg::result_t result,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [14:0]  cfg_data
);

	ahbc_pkg::cfg_t cfg;
	ahbc_pkg::item_t item_s1;
	logic valid_s1;
	ahbc_pkg::cam_t cam_q;
	ahbc_pkg::cam_t cam_nxt;
	ahbc_pkg::result_t beam_result;
	ahbc_pkg::result_t result_q;
	logic result_valid_q;
	logic adv;

	assign cfg_ready = 1'b1;

	ahbc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// stage moves whenever the result register is free or being drained
	assign adv = !result_valid_q || result_ready;
	assign item_ready = !valid_s1 || adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	ahbc_beam u_beam (
		.item    (item_s1),
		.cfg     (cfg),
		.cam     (cam_q),
		.cam_nxt (cam_nxt),
		.result  (beam_result)
	);

	// camera state commits as the beat leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q <= '0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= valid_s1;
			if (valid_s1) cam_q <= cam_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			result_q <= beam_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	// a stalled stage keeps its beat
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("stage beat dropped under stall");

	// manual mode always forces the fallback camera word and error
	a_manual_cam: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && !item_s1.auto_on |=>
			cam_q.word == ahbc_pkg::DEFAULT_WORD && cam_q.error)
		else $error("manual beat left camera state wrong");

	// exactly one beam mode is flagged per result
	a_one_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot(result.status_flags[3:1]))
		else $error("result carries other than one mode flag");

	// camera error flag in a result matches the committed state
	a_err_flag: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 |=> result.status_flags[5] == cam_q.error)
		else $error("video error flag disagrees with camera state");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ahbc_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_ITEMS = 140;

	typedef struct {
		bit      pinned;
		result_t r;
	} pin_t;

	typedef struct {
		item_t   it;
		bit      pinned;
		result_t r;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic [2:0]  cfg_index = REG_THRESH_LOW;
	logic [14:0] cfg_data = '0;

	// predictor copy of the registers and the camera state
	int         thr_lo = int'(RST_THRESH_LOW);
	int         thr_mid = int'(RST_THRESH_MID);
	int         thr_hi = int'(RST_THRESH_HIGH);
	logic [7:0] duty_q = RST_DUTY_QUARTER;
	logic [7:0] duty_h = RST_DUTY_HALF;
	logic [7:0] duty_f = RST_DUTY_FULL;
	logic [7:0] cam_word_p = '0;
	logic       cam_err_p = 1'b0;

	result_t beam_exp_q[$];
	pin_t    pinned_q[$];
	row_t    dir_rows[$];
	int      mismatches = 0;
	int      burst_left = 1;
	int      idle_cycles = 0;
	bit      hold_req = 1'b0;

	adaptive_headlight_beam_control dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// expected beam duties and status for one update
	function automatic result_t beam_predict(input item_t it);
		int         accel;
		int         shift;
		logic [1:0] mode;
		logic [7:0] lowp [12];
		logic [7:0] highp [11];
		logic [7:0] hd [5];
		logic [7:0] ld [6];
		logic [7:0] v;
		logic [5:0] st;
		result_t    r;
		// camera link state
		if (!it.auto_on) begin
			cam_word_p = DEFAULT_WORD;
			cam_err_p = 1'b1;
		end else if (it.video_event == EV_BYTE) begin
			cam_word_p = it.video_byte;
			cam_err_p = 1'b0;
		end else if (it.video_event == EV_TIMEOUT) begin
			cam_word_p = DEFAULT_WORD;
			cam_err_p = 1'b1;
		end
		// beam mode
		if (it.auto_on) begin
			if (cam_word_p[CAM_DARK_BIT])
				mode = cam_word_p[CAM_SPEED_BIT] ? MODE_HIGH : MODE_LOW;
			else
				mode = MODE_DRL;
		end else if (it.manual_high) begin
			mode = MODE_HIGH;
		end else begin
			mode = it.manual_drl ? MODE_DRL : MODE_LOW;
		end
		// pattern windows
		for (int i = 0; i < 12; i++) begin
			lowp[i] = 8'd0;
			if (mode == MODE_DRL) lowp[i] = duty_q;
			else if (mode == MODE_LOW) begin
				if (i < 3) lowp[i] = duty_q;
				else if (i < 7 || i >= 9) lowp[i] = duty_h;
				else lowp[i] = duty_f;
			end
		end
		for (int i = 0; i < 11; i++) begin
			highp[i] = 8'd0;
			if (mode == MODE_HIGH) begin
				if (i == 0 || i == 10) highp[i] = duty_q;
				else if (i < 4 || i == 9) highp[i] = duty_h;
				else highp[i] = duty_f;
			end
		end
		// steering shift, nested compares as they stand
		accel = int'(it.lateral_accel);
		shift = 0;
		if (!it.imu_fault) begin
			if (accel > thr_lo) shift = (accel > thr_mid) ? ((accel > thr_hi) ? -3 : -2) : -1;
			else if (accel < -thr_lo)
				shift = (accel < -thr_mid) ? ((accel < -thr_hi) ? 3 : 2) : 1;
		end
		// slide windows and apply the glare mask
		for (int i = 0; i < 6; i++) ld[i] = lowp[3 + i + shift];
		for (int i = 0; i < 5; i++) begin
			v = highp[3 + i + shift];
			if (it.auto_on && mode == MODE_HIGH) begin
				hd[i] = cam_word_p[4 - i] ? 8'd0 : v;
				ld[i + 1] = cam_word_p[4 - i] ? v : 8'd0;
			end else begin
				hd[i] = v;
			end
		end
		st = it.auto_on ? 6'h00 : 6'h01;
		st |= (mode == MODE_DRL) ? 6'h02 : (mode == MODE_LOW) ? 6'h04 : 6'h08;
		if (it.imu_fault) st |= 6'h10;
		if (cam_err_p) st |= 6'h20;
		r = '{hd[0], hd[1], hd[2], hd[3], hd[4],
			ld[0], ld[1], ld[2], ld[3], ld[4], ld[5], st};
		return r;
	endfunction

	function automatic item_t mk_item(input bit au, input bit mh, input bit md,
			input logic [1:0] ev, input logic [7:0] vb, input int accel, input bit flt);
		item_t it;
		it.auto_on = au;
		it.manual_high = mh;
		it.manual_drl = md;
		it.video_event = ev;
		it.video_byte = vb;
		it.lateral_accel = accel[15:0];
		it.imu_fault = flt;
		return it;
	endfunction

	// acceleration, often near the current thresholds, else random or extreme
	function automatic int pick_accel();
		int t;
		int d;
		int v;
		case ($urandom_range(0, 4))
			0: v = $urandom_range(0, 65535) - 32768;
			1, 2: begin
				case ($urandom_range(0, 2))
					0: t = thr_lo;
					1: t = thr_mid;
					default: t = thr_hi;
				endcase
				d = $urandom_range(0, 4);
				v = t + d - 2;
				if ($urandom_range(0, 1)) v = -v;
			end
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32767;
					1: v = -32768;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: v = $urandom_range(0, 40000) - 20000;
		endcase
		return v;
	endfunction

	function automatic item_t pick_item();
		logic [1:0] ev;
		logic [7:0] vb;
		int         sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) ev = EV_NONE;
		else if (sel < 80) ev = EV_BYTE;
		else if (sel < 92) ev = EV_TIMEOUT;
		else ev = 2'd3;
		vb = 8'($urandom_range(0, 255));
		// keep the dark bit set most of the time so the beam modes spread
		if ($urandom_range(0, 3) != 0) vb[CAM_DARK_BIT] = 1'b1;
		return mk_item($urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), ev, vb, pick_accel(), $urandom_range(0, 9) == 0);
	endfunction

	task automatic add_row(input item_t it, input bit pin, input result_t r);
		row_t row;
		row.it = it;
		row.pinned = pin;
		row.r = r;
		dir_rows.push_back(row);
	endtask

	// offer one beat and hold it until taken
	task automatic offer(input item_t it, input bit pin, input result_t r);
		pin_t p;
		p.pinned = pin;
		p.r = r;
		pinned_q.push_back(p);
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	// bursts of random length with random gaps
	task automatic pace_sender();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// wait for every expected beat, then let the pipeline settle
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (beam_exp_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apply_settings(input int lo, input int mi, input int hi,
			input int dq, input int dh, input int df);
		logic [14:0] data [6];
		logic [2:0]  idx [6];
		logic [6:0]  pad;
		idx = '{REG_THRESH_LOW, REG_THRESH_MID, REG_THRESH_HIGH,
			REG_DUTY_QUARTER, REG_DUTY_HALF, REG_DUTY_FULL};
		data[0] = lo[14:0];
		data[1] = mi[14:0];
		data[2] = hi[14:0];
		pad = 7'($urandom_range(0, 127));
		data[3] = {pad, dq[7:0]};
		pad = 7'($urandom_range(0, 127));
		data[4] = {pad, dh[7:0]};
		pad = 7'($urandom_range(0, 127));
		data[5] = {pad, df[7:0]};
		for (int k = 0; k < 6; k++) begin
			cfg_index <= idx[k];
			cfg_data <= data[k];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic cmp(input string name, input logic [7:0] e, input logic [7:0] a);
		if (a !== e) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			mismatches++;
		end
	endtask

	// predict on each accepted item, check each accepted result
	always @(posedge clk) begin
		pin_t    p;
		result_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THRESH_LOW: thr_lo = int'(cfg_data);
					REG_THRESH_MID: thr_mid = int'(cfg_data);
					REG_THRESH_HIGH: thr_hi = int'(cfg_data);
					REG_DUTY_QUARTER: duty_q = cfg_data[7:0];
					REG_DUTY_HALF: duty_h = cfg_data[7:0];
					REG_DUTY_FULL: duty_f = cfg_data[7:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				e = beam_predict(item);
				p = pinned_q.pop_front();
				if (p.pinned) e = p.r;
				beam_exp_q.push_back(e);
			end
			if (result_valid && result_ready) begin
				if (beam_exp_q.size() == 0) begin
					$error("result beat with no expectation waiting");
					mismatches++;
				end else begin
					e = beam_exp_q.pop_front();
					cmp("high_duty_0", e.high_duty_0, result.high_duty_0);
					cmp("high_duty_1", e.high_duty_1, result.high_duty_1);
					cmp("high_duty_2", e.high_duty_2, result.high_duty_2);
					cmp("high_duty_3", e.high_duty_3, result.high_duty_3);
					cmp("high_duty_4", e.high_duty_4, result.high_duty_4);
					cmp("low_duty_0", e.low_duty_0, result.low_duty_0);
					cmp("low_duty_1", e.low_duty_1, result.low_duty_1);
					cmp("low_duty_2", e.low_duty_2, result.low_duty_2);
					cmp("low_duty_3", e.low_duty_3, result.low_duty_3);
					cmp("low_duty_4", e.low_duty_4, result.low_duty_4);
					cmp("low_duty_5", e.low_duty_5, result.low_duty_5);
					cmp("status_flags", {2'b00, e.status_flags}, {2'b00, result.status_flags});
				end
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// receiver stall patterns and the one long hold-off
	initial begin : result_sink
		int          style;
		int          span;
		logic [15:0] pat;
		while (!arst_n) @(posedge clk);
		forever begin
			style = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			pat = 16'($urandom_range(0, 65535));
			for (int step = 0; step < span; step++) begin
				@(posedge clk);
				if (hold_req) begin
					result_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_req = 1'b0;
					result_ready <= 1'b1;
				end else begin
					case (style)
						0: result_ready <= 1'b1;
						1: result_ready <= 1'($urandom_range(0, 1));
						2: result_ready <= pat[step % 16];
						default: result_ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	initial begin : stimulus
		result_t none;
		int      lo;
		int      mi;
		int      hi;
		none = '0;
		// manual modes at reset settings, results read off directly
		add_row(mk_item(0, 0, 1, EV_NONE, 8'h00, 0, 0), 1,
			result_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
				8'd70, 8'd70, 8'd70, 8'd70, 8'd70, 8'd70, 6'h23});
		add_row(mk_item(0, 1, 0, EV_NONE, 8'h00, 0, 0), 1,
			result_t'{8'd150, 8'd255, 8'd255, 8'd255, 8'd255,
				8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 6'h29});
		add_row(mk_item(0, 0, 0, EV_NONE, 8'h00, 0, 0), 1,
			result_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
				8'd150, 8'd150, 8'd150, 8'd150, 8'd255, 8'd255, 6'h25});
		// sensor fault keeps the beam centred
		add_row(mk_item(0, 1, 1, EV_NONE, 8'h00, 32767, 1), 1,
			result_t'{8'd150, 8'd255, 8'd255, 8'd255, 8'd255,
				8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 6'h39});
		// manual word left over, then camera driven modes
		add_row(mk_item(1, 0, 0, EV_NONE, 8'hff, 0, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_BYTE, 8'h60, 0, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_NONE, 8'hff, 4000, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_NONE, 8'hff, -4000, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_NONE, 8'h00, 4001, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_NONE, 8'h00, -4001, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_BYTE, 8'h7f, 8001, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_BYTE, 8'h75, -8001, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_NONE, 8'h00, 12001, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_NONE, 8'h00, -12001, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_NONE, 8'h00, 32767, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_NONE, 8'h00, -32768, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_BYTE, 8'h20, 8000, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_BYTE, 8'h00, -12000, 0), 0, none);
		// unused event code is no event
		add_row(mk_item(1, 0, 0, 2'd3, 8'hff, 0, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_BYTE, 8'h40, 3000, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_TIMEOUT, 8'h9f, 5000, 0), 0, none);
		add_row(mk_item(1, 1, 1, EV_BYTE, 8'hff, -32768, 1), 0, none);
		// camera events ignored in manual mode
		add_row(mk_item(0, 1, 1, EV_BYTE, 8'hff, -20000, 0), 0, none);
		add_row(mk_item(1, 0, 0, EV_NONE, 8'h00, 12000, 0), 0, none);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			offer(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].r);
			pace_sender();
		end
		drain();

		// random phases, one register setting each
		for (int ph = 1; ph <= 6; ph++) begin
			case (ph)
				1: begin
					lo = $urandom_range(100, 6000);
					mi = lo + $urandom_range(0, 6000);
					hi = mi + $urandom_range(0, 8000);
					apply_settings(lo, mi, hi, $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255));
				end
				2: apply_settings(0, 0, 0, 0, 0, 0);
				3: apply_settings(32767, 32767, 32767, 255, 255, 255);
				4: begin
					// thresholds in the wrong order
					apply_settings($urandom_range(15000, 30000), $urandom_range(5000, 14000),
						$urandom_range(0, 4000), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255));
				end
				5: apply_settings($urandom_range(0, 32767), $urandom_range(0, 32767),
					$urandom_range(0, 32767), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255));
				default: apply_settings(RST_THRESH_LOW, RST_THRESH_MID, RST_THRESH_HIGH,
					RST_DUTY_QUARTER, RST_DUTY_HALF, RST_DUTY_FULL);
			endcase
			if (ph == 1) hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				offer(pick_item(), 1'b0, none);
				pace_sender();
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && beam_exp_q.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
